// File: hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int MAX_TIMERS_DEF = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int NW             = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_CANCEL = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_EXPIRED   = 3'd4
	} kind_t;

	typedef struct packed {
		logic capture;
		logic advance;
		logic scan;
		logic fin_add;
		logic fin_cancel;
		logic take;
		logic emit;
		logic emit_last;
	} ctl_t;

	typedef struct packed {
		logic enable;
		logic scan_done;
		logic found;
		logic out_free;
		logic have_pend;
		logic n_last;
	} sts_t;

endpackage

// File: hw/rtl/dtq_ram.sv
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/dtq_datapath.sv
// ----------------------------------------------------------------------------
// dtq_datapath
// Time base, id counter, slot store, sequential slot scan and result register.
// ----------------------------------------------------------------------------
module dtq_datapath import dtq_pkg::*; #(
	parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic [1:0]  command,
	input  logic [30:0] duration,
	input  logic [15:0] cancel_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [15:0] result_id,
	output logic        last
);

	localparam int IW = $clog2(MAX_TIMERS);
	localparam int CW = $clog2(MAX_TIMERS + 1);

	logic                  enable_q;
	logic [31:0]           now_q;
	logic [15:0]           next_id_q;
	logic [MAX_TIMERS-1:0] valid_q;
	cmd_t                  op_q;
	logic [30:0]           dur_q;
	logic [15:0]           req_id_q;
	logic                  busy_q;
	logic [CW-1:0]         issue_q;
	logic                  pv_s1;
	logic [IW-1:0]         idx_s1;
	logic                  found_q;
	logic [IW-1:0]         best_idx_q;
	logic [31:0]           best_age_q;
	logic [15:0]           best_id_q;
	logic [15:0]           pend_id_q;
	logic                  have_pend_q;
	logic [NW-1:0]         n_q;
	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [15:0]           rid_q;
	logic                  last_q;

	logic [47:0] rdata;
	logic [15:0] e_id;
	logic [31:0] e_dl;
	logic [31:0] e_age;
	logic        e_v;
	logic        hit;
	logic        issuing;
	logic        scan_done;
	logic        out_free;
	logic        ram_we;

	assign issuing   = busy_q && (issue_q != CW'(MAX_TIMERS));
	assign scan_done = busy_q && !issuing && !pv_s1;
	assign out_free  = !out_valid_q || !out_stall;
	assign ram_we    = ctl.fin_add && found_q;

	dtq_ram #(.WIDTH(48), .DEPTH(MAX_TIMERS)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (best_idx_q),
		.wdata ({next_id_q, now_q + {1'b0, dur_q}}),
		.raddr (issue_q[IW-1:0]),
		.rdata (rdata)
	);

	assign e_id  = rdata[47:32];
	assign e_dl  = rdata[31:0];
	assign e_age = now_q - e_dl;
	assign e_v   = valid_q[idx_s1];

	always_comb begin
		hit = 1'b0;
		case (op_q)
			CMD_ADD:    hit = !e_v && !found_q;
			CMD_CANCEL: hit = e_v && (e_id == req_id_q) && !found_q;
			CMD_TICK:   hit = e_v && !e_age[31] && (!found_q || (e_age > best_age_q) ||
				((e_age == best_age_q) && (e_id < best_id_q)));
			default:    hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			now_q       <= '0;
			next_id_q   <= '0;
			valid_q     <= '0;
			busy_q      <= 1'b0;
			issue_q     <= '0;
			pv_s1       <= 1'b0;
			found_q     <= 1'b0;
			have_pend_q <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (ctl.advance) begin
				now_q <= now_q + 32'd1;
			end
			if (ctl.scan) begin
				busy_q  <= 1'b1;
				issue_q <= '0;
				pv_s1   <= 1'b0;
				found_q <= 1'b0;
			end else begin
				pv_s1 <= issuing;
				if (issuing) begin
					issue_q <= issue_q + CW'(1);
				end
				if (scan_done) begin
					busy_q <= 1'b0;
				end
				if (pv_s1 && hit) begin
					found_q <= 1'b1;
				end
			end
			if (ram_we) begin
				valid_q[best_idx_q] <= 1'b1;
				next_id_q           <= next_id_q + 16'd1;
			end
			if ((ctl.fin_cancel && found_q) || ctl.take) begin
				valid_q[best_idx_q] <= 1'b0;
			end
			if (ctl.capture) begin
				have_pend_q <= 1'b0;
				n_q         <= '0;
			end else if (ctl.take) begin
				have_pend_q <= 1'b1;
				n_q         <= n_q + NW'(1);
			end else if (ctl.emit && ctl.emit_last) begin
				have_pend_q <= 1'b0;
			end
			if (ctl.fin_add || ctl.fin_cancel || ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q     <= cmd_t'(command);
			dur_q    <= duration;
			req_id_q <= cancel_id;
		end
		idx_s1 <= issue_q[IW-1:0];
		if (!ctl.scan && pv_s1 && hit) begin
			best_idx_q <= idx_s1;
			best_age_q <= e_age;
			best_id_q  <= e_id;
		end
		if (ctl.take) begin
			pend_id_q <= best_id_q;
		end
		if (ctl.fin_add) begin
			kind_q <= found_q ? KIND_ADDED : KIND_FULL;
			rid_q  <= found_q ? next_id_q : 16'd0;
			last_q <= 1'b1;
		end else if (ctl.fin_cancel) begin
			kind_q <= found_q ? KIND_CANCELLED : KIND_NOT_FOUND;
			rid_q  <= req_id_q;
			last_q <= 1'b1;
		end else if (ctl.emit) begin
			kind_q <= KIND_EXPIRED;
			rid_q  <= pend_id_q;
			last_q <= ctl.emit_last;
		end
	end

	assign sts.enable    = enable_q;
	assign sts.scan_done = scan_done;
	assign sts.found     = found_q;
	assign sts.out_free  = out_free;
	assign sts.have_pend = have_pend_q;
	assign sts.n_last    = (n_q == NW'(MAX_RESULTS - 1));

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign result_id = rid_q;
	assign last      = last_q;

endmodule

// File: hw/rtl/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl
// Command sequencer: scan passes, commit and result emission.
// ----------------------------------------------------------------------------
module dtq_ctrl import dtq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  sts_t       sts,
	output ctl_t       ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;
	cmd_t   op_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					case (cmd_t'(command))
						CMD_TICK: begin
							if (sts.enable) begin
								ctl.advance = 1'b1;
								ctl.scan    = 1'b1;
								state_d     = S_SCAN;
							end
						end
						CMD_ADD, CMD_CANCEL: begin
							ctl.scan = 1'b1;
							state_d  = S_SCAN;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				case (op_q)
					CMD_ADD: begin
						if (sts.out_free) begin
							ctl.fin_add = 1'b1;
							state_d     = S_IDLE;
						end
					end
					CMD_CANCEL: begin
						if (sts.out_free) begin
							ctl.fin_cancel = 1'b1;
							state_d        = S_IDLE;
						end
					end
					CMD_TICK: begin
						if (sts.found) begin
							if (!sts.have_pend || sts.out_free) begin
								ctl.take = 1'b1;
								ctl.emit = sts.have_pend;
								if (sts.n_last) begin
									state_d = S_FLUSH;
								end else begin
									ctl.scan = 1'b1;
									state_d  = S_SCAN;
								end
							end
						end else if (!sts.have_pend) begin
							state_d = S_IDLE;
						end else if (sts.out_free) begin
							ctl.emit      = 1'b1;
							ctl.emit_last = 1'b1;
							state_d       = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= CMD_TICK;
		end else begin
			state_q <= state_d;
			if (ctl.capture) begin
				op_q <= cmd_t'(command);
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// File: hw/rtl/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Multi-timer deadline unit: add, cancel and tick commands over a slot store.
// ----------------------------------------------------------------------------
// One command is handled at a time. Add, cancel and an enabled tick walk the
// slot RAM one slot per cycle, and an enabled tick makes one full pass for each
// timer that it fires, since each pass finds only the earliest deadline. A
// disabled tick and command 3 start no scan. A command waits in its final state
// while the receiver holds off the output. The next command is taken while the
// last result still waits in the output register.
module deadline_timer_queue import dtq_pkg::*; #(
	parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [30:0] duration,
	input  logic [15:0] cancel_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [15:0] result_id,
	output logic        last
);

	ctl_t ctl;
	sts_t sts;

	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.sts      (sts),
		.ctl      (ctl)
	);

	dtq_datapath #(.MAX_TIMERS(MAX_TIMERS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.command   (command),
		.duration  (duration),
		.cancel_id (cancel_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.result_id (result_id),
		.last      (last)
	);

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind != KIND_EXPIRED)) |-> last)
		else $error("add/cancel result without last");

	a_full_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_FULL)) |-> (result_id == 16'd0))
		else $error("full result carries nonzero id");

	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (command == CMD_ADD)) |=> in_stall)
		else $error("add transaction did not start a scan");

endmodule

// File: verif/deadline_timer_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_tb
// Self-checking bench: drives tick, add, cancel and command 3 through the
// timer queue, keeps its own model of the slot store and clock, and compares
// every result transaction field by field with the predicted stream.
// ----------------------------------------------------------------------------
module deadline_timer_queue_tb import dtq_pkg::*; ();

	localparam int          SLOTS       = MAX_TIMERS_DEF;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam int          DRAIN_WAIT  = 400;
	localparam longint      CYCLE_LIMIT = 2000000;

	typedef struct {
		kind_t       kind;
		logic [15:0] id;
		logic        last;
	} timer_event_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [30:0] duration;
	logic [15:0] cancel_id;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [15:0] result_id;
	logic        last;

	// model state
	logic        mdl_enable;
	logic [31:0] mdl_now;
	logic [15:0] mdl_next_id;
	logic        mdl_live [SLOTS];
	logic [15:0] mdl_id [SLOTS];
	logic [31:0] mdl_deadline [SLOTS];

	timer_event_t pending_events [$];
	int           mismatches;
	longint       cycles;
	bit           quiet;
	bit           hold_req;
	int           hold_cnt;

	deadline_timer_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.duration  (duration),
		.cancel_id (cancel_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.result_id (result_id),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("deadline_timer_queue verification failed");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver
	always @(posedge clk) begin
		int gap;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt  <= hold_cnt - 1;
		end else if (hold_req) begin
			out_stall <= 1'b1;
			hold_cnt  <= 600;
			hold_req  <= 1'b0;
		end else begin
			gap = idle_len();
			out_stall <= (gap != 0);
			hold_cnt  <= (gap > 1) ? gap - 1 : 0;
		end
	end

	always @(posedge clk) begin
		timer_event_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d id %0d last %0b",
						kind, result_id, last);
			end else begin
				e = pending_events.pop_front();
				if (kind !== e.kind || result_id !== e.id || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind %0d id %0d last %0b, got kind %0d id %0d last %0b",
							e.kind, e.id, e.last, kind, result_id, last);
				end
			end
		end
	end

	function automatic void push_event(kind_t k, logic [15:0] id, logic l);
		timer_event_t e;
		e.kind = k;
		e.id   = id;
		e.last = l;
		pending_events.push_back(e);
	endfunction

	function automatic void predict(logic [1:0] cmd, logic [30:0] dur, logic [15:0] id);
		int          best;
		int          n;
		logic [31:0] age;
		logic [31:0] best_age;
		bit          done;
		case (cmd)
			CMD_ADD: begin
				done = 0;
				for (int s = 0; s < SLOTS && !done; s++) begin
					if (!mdl_live[s]) begin
						mdl_live[s]     = 1'b1;
						mdl_id[s]       = mdl_next_id;
						mdl_deadline[s] = mdl_now + {1'b0, dur};
						push_event(KIND_ADDED, mdl_next_id, 1'b1);
						mdl_next_id     = mdl_next_id + 16'd1;
						done = 1;
					end
				end
				if (!done)
					push_event(KIND_FULL, 16'd0, 1'b1);
			end
			CMD_CANCEL: begin
				done = 0;
				for (int s = 0; s < SLOTS && !done; s++) begin
					if (mdl_live[s] && mdl_id[s] == id) begin
						mdl_live[s] = 1'b0;
						done = 1;
					end
				end
				push_event(done ? KIND_CANCELLED : KIND_NOT_FOUND, id, 1'b1);
			end
			CMD_TICK: begin
				if (mdl_enable) begin
					mdl_now = mdl_now + 32'd1;
					n = 0;
					do begin
						best     = -1;
						best_age = 0;
						for (int s = 0; s < SLOTS; s++) begin
							age = mdl_now - mdl_deadline[s];
							if (mdl_live[s] && !age[31] && (best < 0 || age > best_age ||
								(age == best_age && mdl_id[s] < mdl_id[best]))) begin
								best     = s;
								best_age = age;
							end
						end
						if (best >= 0) begin
							mdl_live[best] = 1'b0;
							push_event(KIND_EXPIRED, mdl_id[best], 1'b0);
							n++;
						end
					end while (best >= 0 && n < MAX_RESULTS);
					if (n > 0)
						pending_events[$].last = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_cmd(logic [1:0] cmd, logic [30:0] dur, logic [15:0] id);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		duration  <= dur;
		cancel_id <= id;
		do @(posedge clk); while (in_stall);
		predict(cmd, dur, id);
	endtask

	task automatic set_enable(logic v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mdl_enable = v;
	endtask

	function automatic logic [15:0] pick_id();
		int s;
		s = $urandom_range(0, SLOTS - 1);
		if ($urandom_range(0, 3) != 0 && mdl_live[s])
			return mdl_id[s];
		return 16'($urandom);
	endfunction

	function automatic logic [30:0] pick_duration();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 31'($urandom_range(0, 12));
		if (r < 9)
			return 31'($urandom);
		return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
	endfunction

	task automatic test_directed();
		send_cmd(CMD_TICK, 31'd0, 16'd0);
		send_cmd(CMD_CANCEL, 31'd0, 16'd0);
		send_cmd(CMD_CANCEL, 31'd0, 16'hFFFF);
		send_cmd(CMD_UNUSED, 31'h7FFF_FFFF, 16'hFFFF);
		send_cmd(CMD_ADD, 31'd0, 16'd0);
		send_cmd(CMD_ADD, 31'h7FFF_FFFF, 16'hFFFF);
		send_cmd(CMD_ADD, 31'd1, 16'd0);
		set_enable(1'b1);
		send_cmd(CMD_TICK, 31'd0, 16'd0);
		send_cmd(CMD_TICK, 31'd0, 16'd0);
		send_cmd(CMD_TICK, 31'd0, 16'd0);
		for (int i = 0; i < 15; i++)
			send_cmd(CMD_ADD, 31'(i % 3), 16'd0);
		send_cmd(CMD_ADD, 31'd0, 16'd0);
		send_cmd(CMD_CANCEL, 31'd0, 16'd1);
		send_cmd(CMD_TICK, 31'd0, 16'd0);
		send_cmd(CMD_TICK, 31'd0, 16'd0);
		send_cmd(CMD_TICK, 31'd0, 16'd0);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_cmd(CMD_ADD, 31'd5, 16'd0);
		for (int i = 0; i < 8; i++)
			send_cmd(CMD_TICK, 31'd0, 16'd0);
	endtask

	task automatic test_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 36)
				send_cmd(CMD_ADD, pick_duration(), 16'($urandom));
			else if (r < 60)
				send_cmd(CMD_CANCEL, 31'($urandom), pick_id());
			else if (r < 96)
				send_cmd(CMD_TICK, 31'($urandom), 16'($urandom));
			else
				send_cmd(CMD_UNUSED, 31'($urandom), 16'($urandom));
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_TICK;
		duration   = '0;
		cancel_id  = '0;
		out_stall  = 1'b0;
		mismatches = 0;
		cycles     = 0;
		quiet      = 1'b0;
		hold_req   = 1'b0;
		hold_cnt   = 0;
		mdl_enable = 1'b0;
		mdl_now    = '0;
		mdl_next_id = '0;
		for (int s = 0; s < SLOTS; s++) begin
			mdl_live[s]     = 1'b0;
			mdl_id[s]       = '0;
			mdl_deadline[s] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(110);
		set_enable(1'b0);
		test_random(50);
		set_enable(1'b1);
		test_random(100);
		test_random(20);
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("deadline_timer_queue verification clean");
		else
			$display("deadline_timer_queue verification failed");
		$finish;
	end

endmodule

// File: deadline_timer_queue.f
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/dtq_datapath.sv
hw/rtl/dtq_ctrl.sv
hw/rtl/deadline_timer_queue.sv
verif/deadline_timer_queue_tb.sv
